FILE: rtl/ljint_pkg.sv
// shared types and constants for the linear joint interpolator
// no dependencies; imported by ljint_lane, ljint_ctrl and linear_joint_interpolator
`default_nettype none

package ljint_pkg;

    localparam int NJ         = 6;
    localparam int STEPS_DEF  = 2000;
    localparam int JOINTS_DEF = 6;
    localparam int POS_W      = 32;
    localparam int INC_W      = 48;
    localparam int CNT_W      = 16;
    localparam int NST        = 13;

    localparam logic signed [INC_W-1:0] INC_MAX = {1'b0, {(INC_W-1){1'b1}}};
    localparam logic signed [INC_W-1:0] INC_MIN = {1'b1, {(INC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_STEP,
        MODE_SNAP
    } ljint_mode_t;

    typedef struct packed {
        logic [NST-1:0]   ld;
        logic             stage_wr;
        logic             commit;
        logic             apply;
        logic [CNT_W-1:0] mul;
        ljint_mode_t      mode;
        logic             first;
        logic             upd;
    } ljint_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/linear_joint_interpolator.sv
// top level of the linear joint interpolator: control pipeline, joint lanes and result merge
// depends on ljint_pkg, ljint_ctrl and ljint_lane
`default_nettype none

// Six-joint linear interpolator. A beat with cmd high stages a joint target and gives no
// result; a beat with cmd low is a control tick carrying measured positions and gives one
// result beat with the commanded positions and the moving flag. One beat is accepted per
// clock while item_stall is low. On a tick's way to its result, eight stages divide the
// target difference by STEPS through a reciprocal multiply with remainder correction, one
// stage updates the move state, and four stages form start plus increment times step
// count with truncation and saturation. Each joint runs in its own lane; joints at or
// above JOINTS read as zero.

module linear_joint_interpolator
    import ljint_pkg::*;
#(
    parameter int STEPS  = STEPS_DEF,
    parameter int JOINTS = JOINTS_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        item_valid,
    output logic                       item_stall,
    input  wire                        cmd,
    input  wire                        apply_target,
    input  wire logic signed [31:0]    position_0,
    input  wire logic signed [31:0]    position_1,
    input  wire logic signed [31:0]    position_2,
    input  wire logic signed [31:0]    position_3,
    input  wire logic signed [31:0]    position_4,
    input  wire logic signed [31:0]    position_5,
    output logic                       result_valid,
    input  wire                        result_stall,
    output logic signed [31:0]         command_0,
    output logic signed [31:0]         command_1,
    output logic signed [31:0]         command_2,
    output logic signed [31:0]         command_3,
    output logic signed [31:0]         command_4,
    output logic signed [31:0]         command_5,
    output logic                       moving
);

    ljint_ctl_t              ctl;
    logic signed [POS_W-1:0] pos_w [0:NJ-1];
    logic signed [POS_W-1:0] cmd_w [0:NJ-1];

    assign pos_w[0] = position_0;
    assign pos_w[1] = position_1;
    assign pos_w[2] = position_2;
    assign pos_w[3] = position_3;
    assign pos_w[4] = position_4;
    assign pos_w[5] = position_5;

    ljint_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .apply_target (apply_target),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .moving       (moving),
        .ctl          (ctl)
    );

    for (genvar j = 0; j < NJ; j++)
    begin : g_lane
        if (j < JOINTS)
        begin : g_on
            ljint_lane #(
                .STEPS (STEPS)
            ) u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .pos     (pos_w[j]),
                .command (cmd_w[j])
            );
        end
        else
        begin : g_off
            assign cmd_w[j] = '0;
        end
    end

    assign command_0 = cmd_w[0];
    assign command_1 = cmd_w[1];
    assign command_2 = cmd_w[2];
    assign command_3 = cmd_w[3];
    assign command_4 = cmd_w[4];
    assign command_5 = cmd_w[5];

endmodule

`default_nettype wire

FILE: rtl/ljint_lane.sv
// one joint lane: staged target, divide-by-steps pipeline, step multiply and command register
// depends on ljint_pkg; driven by ljint_ctrl
`default_nettype none

module ljint_lane #(
    parameter int STEPS = 2000
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire ljint_pkg::ljint_ctl_t            ctl,
    input  wire logic signed [ljint_pkg::POS_W-1:0] pos,
    output logic signed [ljint_pkg::POS_W-1:0]      command
);
    import ljint_pkg::*;

    localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / 64'(STEPS);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];
    localparam logic [15:0] DIV     = 16'(STEPS);

    // state
    logic signed [POS_W-1:0] staged_reg;
    logic signed [POS_W-1:0] start_reg;
    logic signed [POS_W-1:0] target_reg;
    logic signed [INC_W-1:0] inc_reg;
    logic signed [POS_W-1:0] cmd_reg;

    // carried payload
    logic signed [POS_W-1:0] pos_pipe_reg [0:11];
    logic signed [POS_W-1:0] tgt_pipe_reg [0:11];
    logic signed [POS_W-1:0] start_pipe_reg [8:11];
    logic                    neg_pipe_reg [1:6];

    logic signed [32:0]      s0_diff_reg;
    logic [31:0]             s1_mag_reg;
    logic [31:0]             s2_qe_reg;
    logic [31:0]             s2_mag_reg;
    logic [47:0]             s3_t_reg;
    logic [31:0]             s3_qe_reg;
    logic [31:0]             s3_mag_reg;
    logic [31:0]             s4_qa_reg;
    logic [15:0]             s4_ra_reg;
    logic [15:0]             s5_qe_reg;
    logic [15:0]             s5_ra_reg;
    logic [31:0]             s5_qa_reg;
    logic [31:0]             s6_t_reg;
    logic [15:0]             s6_qe_reg;
    logic [15:0]             s6_ra_reg;
    logic [31:0]             s6_qa_reg;
    logic signed [INC_W-1:0] s7_inc_reg;
    logic signed [INC_W-1:0] s8_inc_reg;
    logic [47:0]             s9_plo_reg;
    logic signed [31:0]      s9_phi_reg;
    logic signed [63:0]      s10_prod_reg;
    logic signed [INC_W-1:0] s11_off_reg;

    // next values
    logic signed [32:0]      diff_next;
    logic [31:0]             mag_next;
    logic [63:0]             p1;
    logic [31:0]             qe1_next;
    logic [47:0]             t1_next;
    logic [47:0]             r1;
    logic [16:0]             r1s;
    logic [31:0]             qa_next;
    logic [15:0]             ra_next;
    logic [63:0]             p2;
    logic [15:0]             qe2_next;
    logic [31:0]             t2_next;
    logic [31:0]             r2;
    logic [16:0]             r2s;
    logic [15:0]             qf;
    logic [47:0]             mag48;
    logic signed [INC_W-1:0] inc_next;
    logic signed [INC_W-1:0] inc_sel;
    logic signed [POS_W-1:0] start_sel;
    logic signed [POS_W-1:0] tgt_sel;
    logic [47:0]             plo_next;
    logic signed [31:0]      hi_ext;
    logic signed [31:0]      mul_ext;
    logic signed [31:0]      phi_next;
    logic signed [63:0]      prod_next;
    logic signed [63:0]      biased;
    logic signed [INC_W-1:0] off_next;
    logic signed [48:0]      sum;
    logic signed [POS_W-1:0] sat_sum;
    logic signed [POS_W-1:0] cmd_next;

    always_comb
    begin
        diff_next = 33'(staged_reg) - 33'(pos);
        mag_next  = s0_diff_reg[32] ? 32'(-s0_diff_reg) : 32'(s0_diff_reg);

        // coarse quotient by reciprocal, low by at most one
        p1       = {32'b0, s1_mag_reg} * {31'b0, RECIP};
        qe1_next = p1[63:32];
        t1_next  = {16'b0, s2_qe_reg} * {32'b0, DIV};

        r1  = {16'b0, s3_mag_reg} - s3_t_reg;
        r1s = r1[16:0];
        if (r1s >= {1'b0, DIV})
        begin
            qa_next = s3_qe_reg + 32'd1;
            ra_next = 16'(r1s - {1'b0, DIV});
        end
        else
        begin
            qa_next = s3_qe_reg;
            ra_next = r1s[15:0];
        end

        // fraction bits from the remainder
        p2       = {16'b0, s4_ra_reg, 16'h0} * {31'b0, RECIP};
        qe2_next = p2[47:32];
        t2_next  = {16'b0, s5_qe_reg} * {16'b0, DIV};

        r2  = {s6_ra_reg, 16'h0} - s6_t_reg;
        r2s = r2[16:0];
        qf  = (r2s >= {1'b0, DIV}) ? s6_qe_reg + 16'd1 : s6_qe_reg;

        mag48 = {s6_qa_reg, qf};
        if (mag48[47])
            inc_next = neg_pipe_reg[6] ? INC_MIN : INC_MAX;
        else if (neg_pipe_reg[6])
            inc_next = -$signed(mag48);
        else
            inc_next = $signed(mag48);

        // move start picks up either the new or the running move
        inc_sel   = ctl.apply ? s7_inc_reg       : inc_reg;
        start_sel = ctl.apply ? pos_pipe_reg[7]  : start_reg;
        tgt_sel   = ctl.apply ? tgt_pipe_reg[7]  : target_reg;

        plo_next = {16'b0, s8_inc_reg[31:0]} * {32'b0, ctl.mul};
        hi_ext   = {{16{s8_inc_reg[47]}}, s8_inc_reg[47:32]};
        mul_ext  = {16'b0, ctl.mul};
        phi_next = hi_ext * mul_ext;

        prod_next = $signed({s9_phi_reg, 32'h0}) + $signed({16'b0, s9_plo_reg});

        // truncate toward zero
        biased   = s10_prod_reg + (s10_prod_reg[63] ? 64'sd65535 : 64'sd0);
        off_next = biased[63:16];

        sum = 49'(start_pipe_reg[11]) + 49'(s11_off_reg);
        if (sum[48:31] == {18{sum[48]}})
            sat_sum = sum[31:0];
        else
            sat_sum = sum[48] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};

        case (ctl.mode)
            MODE_HOLD: cmd_next = ctl.first ? pos_pipe_reg[11] : cmd_reg;
            MODE_STEP: cmd_next = sat_sum;
            MODE_SNAP: cmd_next = tgt_pipe_reg[11];
            default:   cmd_next = cmd_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staged_reg <= '0;
            start_reg  <= '0;
            target_reg <= '0;
            inc_reg    <= '0;
            cmd_reg    <= '0;
        end
        else
        begin
            if (ctl.stage_wr)
                staged_reg <= pos;
            if (ctl.commit && ctl.apply)
            begin
                start_reg  <= pos_pipe_reg[7];
                target_reg <= tgt_pipe_reg[7];
                inc_reg    <= s7_inc_reg;
            end
            if (ctl.upd)
                cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[0])
        begin
            pos_pipe_reg[0] <= pos;
            tgt_pipe_reg[0] <= staged_reg;
            s0_diff_reg     <= diff_next;
        end
        for (int k = 1; k < 12; k++)
        begin
            if (ctl.ld[k] && k != 8)
            begin
                pos_pipe_reg[k] <= pos_pipe_reg[k-1];
                tgt_pipe_reg[k] <= tgt_pipe_reg[k-1];
            end
        end
        for (int k = 2; k < 7; k++)
        begin
            if (ctl.ld[k])
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
        end
        for (int k = 9; k < 12; k++)
        begin
            if (ctl.ld[k])
                start_pipe_reg[k] <= start_pipe_reg[k-1];
        end
        if (ctl.ld[1])
        begin
            s1_mag_reg      <= mag_next;
            neg_pipe_reg[1] <= s0_diff_reg[32];
        end
        if (ctl.ld[2])
        begin
            s2_qe_reg  <= qe1_next;
            s2_mag_reg <= s1_mag_reg;
        end
        if (ctl.ld[3])
        begin
            s3_t_reg   <= t1_next;
            s3_qe_reg  <= s2_qe_reg;
            s3_mag_reg <= s2_mag_reg;
        end
        if (ctl.ld[4])
        begin
            s4_qa_reg <= qa_next;
            s4_ra_reg <= ra_next;
        end
        if (ctl.ld[5])
        begin
            s5_qe_reg <= qe2_next;
            s5_ra_reg <= s4_ra_reg;
            s5_qa_reg <= s4_qa_reg;
        end
        if (ctl.ld[6])
        begin
            s6_t_reg  <= t2_next;
            s6_qe_reg <= s5_qe_reg;
            s6_ra_reg <= s5_ra_reg;
            s6_qa_reg <= s5_qa_reg;
        end
        if (ctl.ld[7])
            s7_inc_reg <= inc_next;
        if (ctl.ld[8])
        begin
            s8_inc_reg        <= inc_sel;
            start_pipe_reg[8] <= start_sel;
            tgt_pipe_reg[8]   <= tgt_sel;
            pos_pipe_reg[8]   <= pos_pipe_reg[7];
        end
        if (ctl.ld[9])
        begin
            s9_plo_reg <= plo_next;
            s9_phi_reg <= phi_next;
        end
        if (ctl.ld[10])
            s10_prod_reg <= prod_next;
        if (ctl.ld[11])
            s11_off_reg <= off_next;
    end

    assign command = cmd_reg;

endmodule

`default_nettype wire

FILE: rtl/ljint_ctrl.sv
// pipeline control: stage valids and stall, tick counter, move and first-tick flags
// depends on ljint_pkg; drives the lanes through ljint_ctl_t
`default_nettype none

module ljint_ctrl #(
    parameter int STEPS = 2000
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         item_valid,
    output logic                        item_stall,
    input  wire                         cmd,
    input  wire                         apply_target,
    output logic                        result_valid,
    input  wire                         result_stall,
    output logic                        moving,
    output ljint_pkg::ljint_ctl_t       ctl
);
    import ljint_pkg::*;

    localparam logic [CNT_W-1:0] DIV = CNT_W'(STEPS);

    logic [NST-1:0]   v_reg;
    logic [NST-1:0]   v_next;
    logic [NST-1:0]   ready;
    logic             ap_reg [0:7];
    ljint_mode_t      mode_pipe_reg [8:11];
    logic             first_pipe_reg [8:11];
    logic             mov_pipe_reg [8:12];
    logic [CNT_W-1:0] mul8_reg;

    logic             active_reg;
    logic             active_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             first_reg;
    logic             first_next;

    logic             take;
    logic             commit;
    logic             act_eff;
    logic [CNT_W-1:0] cnt_eff;
    ljint_mode_t      mode_c;
    logic [CNT_W-1:0] mul_c;
    logic             mov_c;

    always_comb
    begin
        ready[NST-1] = !v_reg[NST-1] || !result_stall;
        for (int k = NST - 2; k >= 0; k--)
            ready[k] = !v_reg[k] || ready[k+1];

        take   = item_valid && ready[0];
        commit = ready[8] && v_reg[7];

        v_next[0] = ready[0] ? (take && !cmd) : v_reg[0];
        for (int k = 1; k < NST; k++)
            v_next[k] = ready[k] ? v_reg[k-1] : v_reg[k];

        // move step for the tick at commit
        act_eff     = ap_reg[7] || active_reg;
        cnt_eff     = ap_reg[7] ? '0 : count_reg;
        mode_c      = MODE_HOLD;
        mul_c       = cnt_eff + CNT_W'(1);
        mov_c       = 1'b0;
        active_next = active_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        if (commit)
        begin
            first_next = 1'b0;
            if (act_eff)
            begin
                if (cnt_eff < DIV)
                begin
                    mode_c      = MODE_STEP;
                    mov_c       = 1'b1;
                    active_next = 1'b1;
                    count_next  = mul_c;
                end
                else
                begin
                    mode_c      = MODE_SNAP;
                    active_next = 1'b0;
                    count_next  = cnt_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            active_reg <= 1'b0;
            count_reg  <= '0;
            first_reg  <= 1'b1;
        end
        else
        begin
            v_reg      <= v_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
            ap_reg[0] <= apply_target;
        for (int k = 1; k < 8; k++)
        begin
            if (ready[k])
                ap_reg[k] <= ap_reg[k-1];
        end
        if (ready[8])
        begin
            mode_pipe_reg[8]  <= mode_c;
            first_pipe_reg[8] <= first_reg;
            mov_pipe_reg[8]   <= mov_c;
            mul8_reg          <= mul_c;
        end
        for (int k = 9; k < 12; k++)
        begin
            if (ready[k])
            begin
                mode_pipe_reg[k]  <= mode_pipe_reg[k-1];
                first_pipe_reg[k] <= first_pipe_reg[k-1];
            end
        end
        for (int k = 9; k < 13; k++)
        begin
            if (ready[k])
                mov_pipe_reg[k] <= mov_pipe_reg[k-1];
        end
    end

    always_comb
    begin
        item_stall   = !ready[0];
        result_valid = v_reg[NST-1];
        moving       = mov_pipe_reg[12];
        ctl.ld       = ready;
        ctl.stage_wr = take && cmd;
        ctl.commit   = commit;
        ctl.apply    = ap_reg[7];
        ctl.mul      = mul8_reg;
        ctl.mode     = mode_pipe_reg[11];
        ctl.first    = first_pipe_reg[11];
        ctl.upd      = ready[NST-1] && v_reg[NST-2];
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DIV)
        else $error("step counter past the step count");

    a_first_once: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_reg) |-> $past(commit))
        else $error("first-tick flag cleared without a tick");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && mode_c == MODE_STEP) |=> (count_reg == mul8_reg && active_reg))
        else $error("counter and step multiplier disagree");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !active_reg && !ap_reg[7]) |=> mode_pipe_reg[8] == MODE_HOLD)
        else $error("idle tick produced a move step");

endmodule

`default_nettype wire
